// ===== rtl/scbe_pkg.sv =====
package scbe_pkg;

    // Width of local and base-frame coordinates inside the block.
    localparam int LW = 40;
    // Width of the CORDIC angle accumulator (32-bit turn plus headroom).
    localparam int ZW = 34;
    localparam int CORDIC_STAGES = 30;
    localparam logic signed [41:0] CORDIC_GAIN_Q30 = 42'sd652032874;

    typedef enum logic [1:0] {
        OP_SQRT,
        OP_DIV,
        OP_ROT,
        OP_VEC
    } t_op;

    typedef struct packed {
        logic                 start;
        t_op                  op;
        logic [63:0]          a;
        logic [31:0]          b;
        logic signed [LW-1:0] x;
        logic signed [LW-1:0] y;
    } t_req;

    typedef struct packed {
        logic                 done;
        logic                 busy;
        logic [63:0]          q;
        logic signed [LW-1:0] x;
        logic signed [LW-1:0] y;
        logic signed [ZW-1:0] z;
    } t_rsp;

    // Arctangent of 2^-i as a fraction of a 32-bit turn.
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/scbe_iter.sv =====
module scbe_iter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  scbe_pkg::t_req i_req,
    output scbe_pkg::t_rsp o_rsp
);

    typedef enum logic {
        U_IDLE,
        U_RUN
    } t_ust;

    localparam logic signed [33:0] QUARTER = 34'sd1073741824;
    localparam logic signed [33:0] HALF    = 34'sd2147483648;

    t_ust               r_st;
    scbe_pkg::t_op      r_op;
    logic [6:0]         r_cnt;
    logic [64:0]        r_rem;
    logic [63:0]        r_root;
    logic [63:0]        r_bit;
    logic [31:0]        r_div;
    logic signed [41:0] r_cx;
    logic signed [41:0] r_cy;
    logic signed [33:0] r_cz;
    logic               r_neg;
    logic               r_done;

    logic signed [41:0] dx, dy, n_cx, n_cy;
    logic signed [33:0] at, n_cz;
    logic signed [33:0] s_ta;
    logic               s_neg;
    logic [64:0]        sq_trial;
    logic [32:0]        dv_rem;
    logic               last;
    logic signed [41:0] vx_in, vy_in;
    logic               n_done;

    always_comb begin
        dx = r_cy >>> r_cnt[4:0];
        dy = r_cx >>> r_cnt[4:0];
        at = 34'(scbe_pkg::atan_turn(r_cnt[4:0]));
        if (r_op == scbe_pkg::OP_ROT) begin
            if (r_cz >= 0) begin
                n_cx = r_cx - dx; n_cy = r_cy + dy; n_cz = r_cz - at;
            end else begin
                n_cx = r_cx + dx; n_cy = r_cy - dy; n_cz = r_cz + at;
            end
        end else begin
            if (r_cy >= 0) begin
                n_cx = r_cx + dx; n_cy = r_cy - dy; n_cz = r_cz + at;
            end else begin
                n_cx = r_cx - dx; n_cy = r_cy + dy; n_cz = r_cz - at;
            end
        end
        sq_trial = {1'b0, r_root} + {1'b0, r_bit};
        dv_rem   = {r_rem[31:0], r_bit[63]};
        case (r_op)
            scbe_pkg::OP_SQRT: last = (r_cnt == 7'd31);
            scbe_pkg::OP_DIV:  last = (r_cnt == 7'd63);
            default:           last = (r_cnt == 7'(scbe_pkg::CORDIC_STAGES - 1));
        endcase
        // Fold the heading into the right half-plane before rotating.
        s_ta  = 34'($signed(i_req.a[31:0]));
        s_neg = 1'b0;
        if (s_ta > QUARTER) begin
            s_ta  = s_ta - HALF;
            s_neg = 1'b1;
        end else if (s_ta < -QUARTER) begin
            s_ta  = s_ta + HALF;
            s_neg = 1'b1;
        end
        vx_in = 42'(i_req.x);
        vy_in = 42'(i_req.y);
        // A vectoring request for the origin finishes at once.
        if (r_st == U_RUN) begin
            n_done = last;
        end else begin
            n_done = i_req.start && (i_req.op == scbe_pkg::OP_VEC) &&
                     (vx_in == 0) && (vy_in == 0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= U_IDLE;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= scbe_pkg::OP_SQRT;
        end else begin
            r_done <= n_done;
            case (r_st)
                U_IDLE: begin
                    if (i_req.start) begin
                        r_op  <= i_req.op;
                        r_cnt <= '0;
                        case (i_req.op)
                            scbe_pkg::OP_SQRT: begin
                                r_rem  <= {1'b0, i_req.a};
                                r_root <= '0;
                                r_bit  <= 64'd1 << 62;
                                r_st   <= U_RUN;
                            end
                            scbe_pkg::OP_DIV: begin
                                r_rem  <= '0;
                                r_root <= '0;
                                r_bit  <= i_req.a;
                                r_div  <= i_req.b;
                                r_st   <= U_RUN;
                            end
                            scbe_pkg::OP_ROT: begin
                                r_cx  <= scbe_pkg::CORDIC_GAIN_Q30;
                                r_cy  <= '0;
                                r_cz  <= s_ta;
                                r_neg <= s_neg;
                                r_st  <= U_RUN;
                            end
                            default: begin
                                // A point at the origin has bearing zero.
                                if (vx_in == 0 && vy_in == 0) begin
                                    r_cz   <= '0;
                                end else if (vx_in < 0) begin
                                    r_cx <= -vx_in;
                                    r_cy <= -vy_in;
                                    r_cz <= HALF;
                                    r_st <= U_RUN;
                                end else begin
                                    r_cx <= vx_in;
                                    r_cy <= vy_in;
                                    r_cz <= '0;
                                    r_st <= U_RUN;
                                end
                            end
                        endcase
                    end
                end
                U_RUN: begin
                    r_cnt <= r_cnt + 7'd1;
                    case (r_op)
                        scbe_pkg::OP_SQRT: begin
                            if (r_rem >= sq_trial) begin
                                r_rem  <= r_rem - sq_trial;
                                r_root <= (r_root >> 1) + r_bit;
                            end else begin
                                r_root <= r_root >> 1;
                            end
                            r_bit <= r_bit >> 2;
                        end
                        scbe_pkg::OP_DIV: begin
                            if (dv_rem >= {1'b0, r_div}) begin
                                r_rem  <= 65'(dv_rem - {1'b0, r_div});
                                r_root <= {r_root[62:0], 1'b1};
                            end else begin
                                r_rem  <= 65'(dv_rem);
                                r_root <= {r_root[62:0], 1'b0};
                            end
                            r_bit <= r_bit << 1;
                        end
                        default: begin
                            r_cz <= n_cz;
                            if (last && r_op == scbe_pkg::OP_ROT && r_neg) begin
                                r_cx <= -n_cx;
                                r_cy <= -n_cy;
                            end else begin
                                r_cx <= n_cx;
                                r_cy <= n_cy;
                            end
                        end
                    endcase
                    if (last) begin
                        r_st   <= U_IDLE;
                    end
                end
                default: r_st <= U_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = (r_st == U_RUN);
    assign o_rsp.q    = r_root;
    assign o_rsp.x    = 40'(r_cx);
    assign o_rsp.y    = 40'(r_cy);
    assign o_rsp.z    = r_cz;

endmodule

// ===== rtl/swing_circle_box_entry_point_top.sv =====
// Swing-circle entry point onto a rotated box.
// Input channel s_axis: one item holds start, goal and box centre points, the box
// heading (tdata) and the turn direction (tuser). Output channel m_axis: one result
// with the result kind (tuser) and the chosen point (tdata).
// The configuration port writes the radius blend and the box extents; write it only
// while no item is in flight.
// One item is worked at a time by a sequencer around one registered multiplier and
// one iterative unit (square root, 64-bit division, CORDIC rotation and vectoring).
// The time from the input transfer to m_axis_tvalid is data dependent: shortest when
// the radius is zero, longer when hits are found (up to eight are tested) and on the
// projection fallback.
// s_axis_tready is high only while the sequencer is idle, so a new item is taken only
// after the previous one is finished; the next item is taken even while the previous
// result still waits in the output register.
// If the receiver stalls, the finished item waits until the output register is free.
// Reset (synchronous, active low) returns the sequencer to idle, drops m_axis_tvalid
// and loads the default configuration.
module swing_circle_box_entry_point_top #(
    parameter int COORD_WIDTH = 32,
    parameter int ANGLE_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // start_x, start_y, goal_x, goal_y, box_center_x, box_center_y, box_heading
    input  logic [((6*COORD_WIDTH+ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // turn_ccw
    input  logic                                          s_axis_tuser,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // entry_x, entry_y
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]            m_axis_tdata,
    // result_kind
    output logic [1:0]                                    m_axis_tuser,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    input  logic                                          i_cfg_we,
    input  logic [1:0]                                    i_cfg_idx,
    input  logic [30:0]                                   i_cfg_data
);

    localparam int CW    = COORD_WIDTH;
    localparam int AB    = ANGLE_BITS;
    localparam int OUT_W = ((2*CW+7)/8)*8;
    localparam logic signed [63:0] OMAX = (64'sd1 <<< (CW-1)) - 64'sd1;
    localparam logic signed [63:0] OMIN = -OMAX - 64'sd1;

    localparam logic [1:0] REG_BLEND  = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_WIDTH  = 2'd2;

    localparam logic [1:0] KIND_FAIL = 2'd0;
    localparam logic [1:0] KIND_HIT  = 2'd1;
    localparam logic [1:0] KIND_PROJ = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE, S_R1A, S_R1B, S_R1C, S_R1W, S_R2A, S_R2B, S_R2C, S_R2W,
        S_BLA, S_BLB, S_BLC, S_RCHK, S_SCW, S_OXA, S_OXB, S_OXC, S_OYA, S_OYB,
        S_RSQ, S_SAW, S_EDGE, S_EM, S_ESW, S_HIT, S_WXA, S_WXB, S_WXC, S_WYA,
        S_WYB, S_WVEC, S_WVW, S_KNEXT, S_ENEXT, S_NEAR, S_NA, S_NB, S_NC, S_PV,
        S_PVW, S_QXA, S_QXB, S_QXW, S_QYA, S_QYB, S_QYW, S_FXA, S_FXB, S_FXC,
        S_FYA, S_FYB, S_EMIT
    } t_state;

    // Configuration.
    logic [16:0] r_blend;
    logic [30:0] r_blen;
    logic [30:0] r_bwid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend <= 17'd32768;
            r_blen  <= 31'd524288;
            r_bwid  <= 31'd163840;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLEND:  r_blend <= i_cfg_data[16:0];
                REG_LENGTH: r_blen  <= i_cfg_data;
                REG_WIDTH:  r_bwid  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state              r_state;
    logic signed [31:0]  r_v0, r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [AB-1:0]       r_head;
    logic                r_ccw;
    logic signed [71:0]  r_prod;
    logic signed [71:0]  r_acc;
    logic [31:0]         r_r1, r_r2, r_rad, r_s, r_vn;
    logic [63:0]         r_rsq;
    logic signed [35:0]  r_cs, r_sn;
    logic signed [39:0]  r_ox, r_oy, r_ix, r_iy, r_wx, r_wy, r_wbx, r_wby;
    logic signed [39:0]  r_ax, r_ay, r_qx, r_qy, r_nx, r_ny, r_vx, r_vy;
    logic signed [39:0]  r_ux, r_uy, r_rx, r_ry;
    logic [AB-1:0]       r_sa, r_best;
    logic                r_found;
    logic [64:0]         r_bd;
    logic [1:0]          r_e;
    logic                r_k;
    logic [1:0]          r_rk;
    logic                r_ovalid;
    logic [1:0]          r_okind;
    logic [CW-1:0]       r_odx, r_ody;

    scbe_pkg::t_req req;
    scbe_pkg::t_rsp rsp;

    scbe_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    function automatic logic signed [31:0] sat_in(input logic [CW-1:0] f);
        logic signed [63:0] e;
        e = 64'($signed(f));
        if (e > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (e < -64'sd2147483648) return 32'h8000_0000;
        return 32'(e);
    endfunction

    function automatic logic [CW-1:0] sat_out(input logic signed [39:0] a);
        logic signed [63:0] e;
        e = 64'(a);
        if (e > OMAX) e = OMAX;
        if (e < OMIN) e = OMIN;
        return CW'(e);
    endfunction

    function automatic logic signed [39:0] rnd30(input logic signed [71:0] a);
        return 40'((a + 72'sd536870912) >>> 30);
    endfunction

    // Edge geometry for the current edge: x=-L/2, x=+L/2, y=-W/2, y=+W/2.
    logic               g_vert, g_big, g_out, g_zero;
    logic signed [39:0] g_hl, g_hw, g_h, g_span, g_pos, g_ctr, g_off, g_mag;
    logic signed [39:0] g_t, g_ix, g_iy, g_along, g_qx, g_qy, g_dx, g_dy;
    logic signed [39:0] g_vx, g_vy, g_avx, g_avy;
    logic [16:0]        g_w;
    logic [AB-1:0]      g_ang, g_diff;
    logic [64:0]        g_sum;
    logic signed [35:0] mul_a, mul_b;

    always_comb begin
        g_vert = ~r_e[1];
        g_hl   = $signed(40'(r_blen[30:1]));
        g_hw   = $signed(40'(r_bwid[30:1]));
        g_h    = g_vert ? g_hl : g_hw;
        g_span = g_vert ? g_hw : g_hl;
        g_pos  = r_e[0] ? g_h : -g_h;
        g_ctr  = g_vert ? r_oy : r_ox;
        g_off  = (g_vert ? r_ox : r_oy) - g_pos;
        g_mag  = (g_off < 0) ? -g_off : g_off;
        g_big  = |g_mag[39:32];
        g_t    = r_k ? g_ctr - $signed(40'(r_s)) : g_ctr + $signed(40'(r_s));
        g_ix   = g_vert ? g_pos : g_t;
        g_iy   = g_vert ? g_t : g_pos;
        g_out  = (g_t < -g_span) || (g_t > g_span);
        g_zero = (g_ix == 0) && (g_iy == 0);
        // A degenerate edge counts as a point at its first corner.
        if (g_span <= 40'sd1)       g_along = -g_span;
        else if (g_ctr < -g_span)   g_along = -g_span;
        else if (g_ctr > g_span)    g_along = g_span;
        else                        g_along = g_ctr;
        g_qx   = g_vert ? g_pos : g_along;
        g_qy   = g_vert ? g_along : g_pos;
        g_dx   = g_qx - r_ox;
        g_dy   = g_qy - r_oy;
        g_sum  = {1'b0, r_acc[63:0]} + {1'b0, r_prod[63:0]};
        g_vx   = r_nx - r_ox;
        g_vy   = r_ny - r_oy;
        g_avx  = (r_vx < 0) ? -r_vx : r_vx;
        g_avy  = (r_vy < 0) ? -r_vy : r_vy;
        g_w    = (r_blend > 17'd65536) ? 17'd65536 : r_blend;
        g_ang  = rsp.z[31 -: AB];
        g_diff = r_ccw ? (g_ang - r_sa) : (r_sa - g_ang);
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_R1A:  begin mul_a = 36'(r_v0); mul_b = 36'(r_v0); end
            S_R1B:  begin mul_a = 36'(r_v1); mul_b = 36'(r_v1); end
            S_R2A:  begin mul_a = 36'(r_v2); mul_b = 36'(r_v2); end
            S_R2B:  begin mul_a = 36'(r_v3); mul_b = 36'(r_v3); end
            S_BLA:  begin mul_a = 36'(g_w); mul_b = 36'(r_r1); end
            S_BLB:  begin mul_a = 36'(17'd65536 - g_w); mul_b = 36'(r_r2); end
            S_OXA:  begin mul_a = r_cs; mul_b = 36'(r_v4); end
            S_OXB:  begin mul_a = r_sn; mul_b = 36'(r_v5); end
            S_OXC:  begin mul_a = r_sn; mul_b = 36'(r_v4); end
            S_OYA:  begin mul_a = r_cs; mul_b = 36'(r_v5); end
            S_OYB:  begin mul_a = 36'(r_rad); mul_b = 36'(r_rad); end
            S_EDGE: begin mul_a = 36'(g_mag); mul_b = 36'(g_mag); end
            S_WXA:  begin mul_a = r_cs; mul_b = 36'(r_ix); end
            S_WXB:  begin mul_a = r_sn; mul_b = 36'(r_iy); end
            S_WXC:  begin mul_a = r_sn; mul_b = 36'(r_ix); end
            S_WYA:  begin mul_a = r_cs; mul_b = 36'(r_iy); end
            S_NA:   begin mul_a = 36'(r_ax); mul_b = 36'(r_ax); end
            S_NB:   begin mul_a = 36'(r_ay); mul_b = 36'(r_ay); end
            S_QXA:  begin mul_a = 36'(r_rad); mul_b = 36'(g_avx); end
            S_QYA:  begin mul_a = 36'(r_rad); mul_b = 36'(g_avy); end
            S_FXA:  begin mul_a = r_cs; mul_b = 36'(r_ux); end
            S_FXB:  begin mul_a = r_sn; mul_b = 36'(r_uy); end
            S_FXC:  begin mul_a = r_sn; mul_b = 36'(r_ux); end
            S_FYA:  begin mul_a = r_cs; mul_b = 36'(r_uy); end
            default: ;
        endcase
    end

    // Requests to the iterative unit.
    always_comb begin
        req       = '0;
        req.op    = scbe_pkg::OP_SQRT;
        case (r_state)
            S_R1C, S_R2C: begin
                req.start = 1'b1;
                req.a     = r_acc[63:0] + r_prod[63:0];
            end
            S_RCHK: begin
                req.start = (r_rad != 32'd0);
                req.op    = scbe_pkg::OP_ROT;
                req.a     = 64'(32'(r_head) << (32 - AB));
            end
            S_RSQ: begin
                req.start = 1'b1;
                req.op    = scbe_pkg::OP_VEC;
                req.x     = 40'(r_v0);
                req.y     = 40'(r_v1);
            end
            S_EM: begin
                req.start = !(r_prod > $signed(72'(r_rsq)));
                req.a     = r_rsq - r_prod[63:0];
            end
            S_WVEC: begin
                req.start = 1'b1;
                req.op    = scbe_pkg::OP_VEC;
                req.x     = r_wx;
                req.y     = r_wy;
            end
            S_PV: begin
                req.start = !(g_vx == 0 && g_vy == 0);
                req.a     = r_bd[64] ? 64'hFFFF_FFFF_FFFF_FFFF : r_bd[63:0];
            end
            S_QXB, S_QYB: begin
                req.start = 1'b1;
                req.op    = scbe_pkg::OP_DIV;
                req.a     = r_prod[63:0] + 64'(r_vn >> 1);
                req.b     = r_vn;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
            r_e      <= '0;
            r_k      <= 1'b0;
        end else begin
            r_prod <= mul_a * mul_b;
            // The emit state only leaves once the output register is free or freeing.
            r_ovalid <= (r_state == S_EMIT) || (r_ovalid && !m_axis_tready);
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_v0   <= sat_in(s_axis_tdata[0*CW +: CW]);
                        r_v1   <= sat_in(s_axis_tdata[1*CW +: CW]);
                        r_v2   <= sat_in(s_axis_tdata[2*CW +: CW]);
                        r_v3   <= sat_in(s_axis_tdata[3*CW +: CW]);
                        r_v4   <= sat_in(s_axis_tdata[4*CW +: CW]);
                        r_v5   <= sat_in(s_axis_tdata[5*CW +: CW]);
                        r_head <= s_axis_tdata[6*CW +: AB];
                        r_ccw  <= s_axis_tuser;
                        r_state <= S_R1A;
                    end
                end
                S_R1A: r_state <= S_R1B;
                S_R1B: begin r_acc <= r_prod; r_state <= S_R1C; end
                S_R1C: r_state <= S_R1W;
                S_R1W: if (rsp.done) begin r_r1 <= rsp.q[31:0]; r_state <= S_R2A; end
                S_R2A: r_state <= S_R2B;
                S_R2B: begin r_acc <= r_prod; r_state <= S_R2C; end
                S_R2C: r_state <= S_R2W;
                S_R2W: if (rsp.done) begin r_r2 <= rsp.q[31:0]; r_state <= S_BLA; end
                S_BLA: r_state <= S_BLB;
                S_BLB: begin r_acc <= r_prod; r_state <= S_BLC; end
                S_BLC: begin
                    r_rad   <= 32'((r_acc + r_prod + 72'sd32768) >>> 16);
                    r_state <= S_RCHK;
                end
                S_RCHK: begin
                    if (r_rad == 32'd0) begin
                        r_rk    <= KIND_FAIL;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_SCW;
                    end
                end
                S_SCW: begin
                    if (rsp.done) begin
                        r_cs    <= 36'(rsp.x);
                        r_sn    <= 36'(rsp.y);
                        r_state <= S_OXA;
                    end
                end
                S_OXA: r_state <= S_OXB;
                S_OXB: begin r_acc <= -r_prod; r_state <= S_OXC; end
                S_OXC: begin r_ox <= rnd30(r_acc - r_prod); r_state <= S_OYA; end
                S_OYA: begin r_acc <= r_prod; r_state <= S_OYB; end
                S_OYB: begin r_oy <= rnd30(r_acc - r_prod); r_state <= S_RSQ; end
                S_RSQ: begin r_rsq <= r_prod[63:0]; r_state <= S_SAW; end
                S_SAW: begin
                    if (rsp.done) begin
                        r_sa    <= g_ang;
                        r_found <= 1'b0;
                        r_e     <= '0;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: r_state <= g_big ? S_ENEXT : S_EM;
                S_EM: begin
                    if (r_prod > $signed(72'(r_rsq))) r_state <= S_ENEXT;
                    else                              r_state <= S_ESW;
                end
                S_ESW: begin
                    if (rsp.done) begin
                        r_s     <= rsp.q[31:0];
                        r_k     <= 1'b0;
                        r_state <= S_HIT;
                    end
                end
                S_HIT: begin
                    // Hits off the edge and a hit at the box centre are skipped.
                    if (g_out || g_zero) begin
                        r_state <= S_KNEXT;
                    end else begin
                        r_ix    <= g_ix;
                        r_iy    <= g_iy;
                        r_state <= S_WXA;
                    end
                end
                S_WXA: r_state <= S_WXB;
                S_WXB: begin r_acc <= r_prod; r_state <= S_WXC; end
                S_WXC: begin
                    r_wx    <= rnd30(r_acc - r_prod) + 40'(r_v4);
                    r_state <= S_WYA;
                end
                S_WYA: begin r_acc <= r_prod; r_state <= S_WYB; end
                S_WYB: begin
                    r_wy    <= rnd30(r_acc + r_prod) + 40'(r_v5);
                    r_state <= S_WVEC;
                end
                S_WVEC: r_state <= S_WVW;
                S_WVW: begin
                    if (rsp.done) begin
                        // Strictly smaller turn wins, so the earliest of equals stays.
                        if (!r_found || g_diff < r_best) begin
                            r_found <= 1'b1;
                            r_best  <= g_diff;
                            r_wbx   <= r_wx;
                            r_wby   <= r_wy;
                        end
                        r_state <= S_KNEXT;
                    end
                end
                S_KNEXT: begin
                    if (!r_k) begin
                        r_k     <= 1'b1;
                        r_state <= S_HIT;
                    end else begin
                        r_state <= S_ENEXT;
                    end
                end
                S_ENEXT: begin
                    if (r_e == 2'd3) begin
                        r_e <= '0;
                        if (r_found) begin
                            r_rk    <= KIND_HIT;
                            r_rx    <= r_wbx;
                            r_ry    <= r_wby;
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_NEAR;
                        end
                    end else begin
                        r_e     <= r_e + 2'd1;
                        r_state <= S_EDGE;
                    end
                end
                S_NEAR: begin
                    r_qx    <= g_qx;
                    r_qy    <= g_qy;
                    r_ax    <= (g_dx < 0) ? -g_dx : g_dx;
                    r_ay    <= (g_dy < 0) ? -g_dy : g_dy;
                    r_state <= S_NA;
                end
                S_NA: r_state <= S_NB;
                S_NB: begin r_acc <= r_prod; r_state <= S_NC; end
                S_NC: begin
                    if (r_e == 2'd0 || g_sum < r_bd) begin
                        r_bd <= g_sum;
                        r_nx <= r_qx;
                        r_ny <= r_qy;
                    end
                    if (r_e == 2'd3) begin
                        r_state <= S_PV;
                    end else begin
                        r_e     <= r_e + 2'd1;
                        r_state <= S_NEAR;
                    end
                end
                S_PV: begin
                    r_vx <= g_vx;
                    r_vy <= g_vy;
                    if (g_vx == 0 && g_vy == 0) begin
                        r_rk    <= KIND_FAIL;
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_PVW;
                    end
                end
                S_PVW: if (rsp.done) begin r_vn <= rsp.q[31:0]; r_state <= S_QXA; end
                S_QXA: r_state <= S_QXB;
                S_QXB: r_state <= S_QXW;
                S_QXW: begin
                    if (rsp.done) begin
                        r_ux    <= (r_vx < 0) ? -40'(rsp.q) : 40'(rsp.q);
                        r_state <= S_QYA;
                    end
                end
                S_QYA: r_state <= S_QYB;
                S_QYB: r_state <= S_QYW;
                S_QYW: begin
                    if (rsp.done) begin
                        r_uy    <= (r_vy < 0) ? -40'(rsp.q) : 40'(rsp.q);
                        r_state <= S_FXA;
                    end
                end
                S_FXA: r_state <= S_FXB;
                S_FXB: begin r_acc <= r_prod; r_state <= S_FXC; end
                S_FXC: begin r_rx <= rnd30(r_acc - r_prod); r_state <= S_FYA; end
                S_FYA: begin r_acc <= r_prod; r_state <= S_FYB; end
                S_FYB: begin
                    r_ry    <= rnd30(r_acc + r_prod);
                    r_rk    <= KIND_PROJ;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_okind  <= r_rk;
                        r_odx    <= sat_out(r_rx);
                        r_ody    <= sat_out(r_ry);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_okind;
    assign m_axis_tdata  = OUT_W'({r_ody, r_odx});

    // The unit is never started while it is still iterating.
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.start |-> !rsp.busy)
        else $error("iterative unit started while busy");

    // Accepting an item requires the unit to be free.
    a_ready_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !rsp.busy)
        else $error("input ready while the unit is busy");

    // Ready drops only on an input transfer.
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(s_axis_tvalid))
        else $error("ready fell without a transfer");

    // A failed result carries a zero point.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_FAIL) |-> (m_axis_tdata == '0))
        else $error("failure result with non-zero point");

endmodule
